@@ design/nde_pkg.sv @@
// shared types and constants for the neighbor difference edge marker
`timescale 1ns / 1ps
package nde_pkg;

   localparam int MaxWidth  = 2048;
   localparam int MaxHeight = 4096;
   localparam int AddrW     = $clog2(MaxWidth);
   localparam int RowW      = 12;
   localparam int ChanW     = 8;
   localparam int PixW      = 3 * ChanW;
   localparam int WidthW    = 12;
   localparam int HeightW   = 13;
   localparam int ThreshW   = 10;
   localparam int QuantW    = 4;
   localparam int PaddrW    = 4;
   localparam int DataW     = 32;

   localparam logic [ChanW-1:0] ChanMax = 8'hFF;

   localparam logic [ThreshW-1:0] ResetThreshold = 10'd1;
   localparam logic [QuantW-1:0]  ResetQuant     = 4'd1;
   localparam logic [WidthW-1:0]  ResetWidth     = 12'd640;
   localparam logic [HeightW-1:0] ResetHeight    = 13'd480;

   typedef enum logic [1:0] {
      RegThreshold = 2'd0,
      RegQuant     = 2'd1,
      RegWidth     = 2'd2,
      RegHeight    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [ThreshW-1:0] diff_threshold;
      logic [QuantW-1:0]  quant_bits;
      logic [WidthW-1:0]  frame_width;
      logic [HeightW-1:0] frame_height;
   } cfg_type;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } pixel_type;

endpackage

@@ design/nde_csr.sv @@
// apb register file holding threshold, quantizer and frame geometry
`timescale 1ns / 1ps
module nde_csr import nde_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [PaddrW-1:0] paddr,
   input  logic [DataW-1:0]  pwdata,
   output logic [DataW-1:0]  prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[PaddrW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            RegThreshold: cfg_in.diff_threshold = pwdata[ThreshW-1:0];
            RegQuant:     cfg_in.quant_bits     = pwdata[QuantW-1:0];
            RegWidth:     cfg_in.frame_width    = pwdata[WidthW-1:0];
            RegHeight:    cfg_in.frame_height   = pwdata[HeightW-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         RegThreshold: prdata = DataW'(cfg_ff.diff_threshold);
         RegQuant:     prdata = DataW'(cfg_ff.quant_bits);
         RegWidth:     prdata = DataW'(cfg_ff.frame_width);
         RegHeight:    prdata = DataW'(cfg_ff.frame_height);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.diff_threshold <= ResetThreshold;
         cfg_ff.quant_bits     <= ResetQuant;
         cfg_ff.frame_width    <= ResetWidth;
         cfg_ff.frame_height   <= ResetHeight;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/nde_line_ram.sv @@
// one-line pixel store, read-first, registered read data
`timescale 1ns / 1ps
module nde_line_ram import nde_pkg::*; (
   input  logic             clock,
   input  logic             access,
   input  logic [AddrW-1:0] addr,
   input  pixel_type        wdata,
   output pixel_type        rdata
);

   pixel_type mem [MaxWidth];
   pixel_type rdata_ff;

   assign rdata = rdata_ff;

   // old contents come out, new pixel goes in at the same address
   always_ff @(posedge clock) begin
      if (access) begin
         rdata_ff   <= mem[addr];
         mem[addr]  <= wdata;
      end
   end

endmodule

@@ design/nde_mark.sv @@
// edge decision: center against its right and lower neighbors
`timescale 1ns / 1ps
module nde_mark import nde_pkg::*; (
   input  cfg_type   cfg,
   input  pixel_type center,
   input  pixel_type right,
   input  pixel_type lower,
   output logic      marked
);

   function automatic logic [ChanW-1:0] absdiff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
      logic [ChanW-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d;
   endfunction

   function automatic logic differs(input pixel_type a, input pixel_type b,
                                    input cfg_type c);
      logic [ThreshW-1:0] sad;
      logic [QuantW-1:0]  q;
      logic [ChanW-1:0]   mask;
      logic               res;
      sad = ThreshW'(absdiff(a.red, b.red)) + ThreshW'(absdiff(a.green, b.green))
            + ThreshW'(absdiff(a.blue, b.blue));
      q    = (c.quant_bits > QuantW'(ChanW)) ? QuantW'(ChanW) : c.quant_bits;
      // top q bits of a channel
      mask = ~(ChanMax >> q);
      if (c.diff_threshold != '0) begin
         res = sad > c.diff_threshold;
      end else begin
         res = (((a.red ^ b.red) | (a.green ^ b.green) | (a.blue ^ b.blue)) & mask) != '0;
      end
      return res;
   endfunction

   assign marked = differs(center, right, cfg) || differs(center, lower, cfg);

endmodule

@@ design/neighbor_difference_edge_marker_unit.sv @@
// top level: raster pixel stream in, edge-marked pixels out
`timescale 1ns / 1ps
// usage
//  - req channel takes one rgb pixel per beat in raster order; the frame
//    geometry comes from frame_width and frame_height over the apb port
//  - when pixel (x,y) with x and y both nonzero is taken, pixel (x-1,y-1)
//    leaves on the rsp channel, red when it differs from its right or lower
//    neighbor; the last row and column never leave
//  - throughput is one pixel per cycle unless rsp_stall holds the output: the
//    line ram is read and written at the same address in the cycle a pixel is
//    taken, and the compare stage sits on its registered read data
//  - a result beat passes through the compare stage, then the output register
//  - rsp_stall holds the output register; the compare stage still takes
//    one more pixel behind it, then req_stall rises until the output drains
//  - reset clears counters, the left and upper-left pixels and the pipeline
//    valid bits; the line ram is not cleared, the first row refills it
//  - registers are to be written only while the stream is idle (not enforced)
module neighbor_difference_edge_marker_unit import nde_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // pixel in
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ChanW-1:0]  req_in_red,
   input  logic [ChanW-1:0]  req_in_green,
   input  logic [ChanW-1:0]  req_in_blue,
   // marked pixel out
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [AddrW-1:0]  rsp_out_col,
   output logic [RowW-1:0]   rsp_out_row,
   output logic [ChanW-1:0]  rsp_out_red,
   output logic [ChanW-1:0]  rsp_out_green,
   output logic [ChanW-1:0]  rsp_out_blue,
   output logic              rsp_marked,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [PaddrW-1:0] paddr,
   input  logic [DataW-1:0]  pwdata,
   output logic [DataW-1:0]  prdata,
   output logic              pready
);

   cfg_type cfg;

   // raster position of the next pixel
   logic [AddrW-1:0]   col_ff, col_in;
   logic [RowW-1:0]    row_ff, row_in;
   logic [WidthW-1:0]  width_lim;
   logic [HeightW-1:0] height_lim;
   logic [WidthW-1:0]  col_next;
   logic [HeightW-1:0] row_inc;

   // compare stage, lined up with the ram read data
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_emit_ff;
   logic [AddrW-1:0] s1_col_ff;
   logic [RowW-1:0]  s1_row_ff;
   pixel_type        s1_cur_ff;

   // neighbors kept across pixels
   pixel_type left_ff, ul_ff;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [AddrW-1:0] rsp_col_ff;
   logic [RowW-1:0]  rsp_row_ff;
   pixel_type        rsp_pix_ff;
   logic             rsp_marked_ff;

   logic      accept;
   logic      out_free;
   logic      s1_adv;
   logic      emit;
   logic      marked;
   pixel_type cur;
   pixel_type up;

   nde_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign cur = '{red: req_in_red, green: req_in_green, blue: req_in_blue};

   nde_line_ram u_line_ram (
      .clock  (clock),
      .access (accept),
      .addr   (col_ff),
      .wdata  (cur),
      .rdata  (up)
   );

   // pixel held in ul is compared against the one above the current pixel
   // (its right neighbor) and the previous pixel (its lower neighbor)
   nde_mark u_mark (
      .cfg    (cfg),
      .center (ul_ff),
      .right  (up),
      .lower  (left_ff),
      .marked (marked)
   );

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // clamp geometry to the supported range
   always_comb begin
      if (cfg.frame_width < WidthW'(2)) begin
         width_lim = WidthW'(2);
      end else if (cfg.frame_width > WidthW'(MaxWidth)) begin
         width_lim = WidthW'(MaxWidth);
      end else begin
         width_lim = cfg.frame_width;
      end
      if (cfg.frame_height < HeightW'(2)) begin
         height_lim = HeightW'(2);
      end else if (cfg.frame_height > HeightW'(MaxHeight)) begin
         height_lim = HeightW'(MaxHeight);
      end else begin
         height_lim = cfg.frame_height;
      end
   end

   assign col_next = WidthW'(col_ff) + WidthW'(1);
   assign row_inc  = HeightW'(row_ff) + HeightW'(1);
   assign emit     = (col_ff != '0) && (row_ff != '0);

   // counters wrap as soon as the next value reaches the limit
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= width_lim) begin
            col_in = '0;
            if (row_inc >= height_lim) begin
               row_in = '0;
            end else begin
               row_in = row_inc[RowW-1:0];
            end
         end else begin
            col_in = col_next[AddrW-1:0];
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = s1_emit_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         ul_ff        <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            ul_ff   <= up;
            left_ff <= s1_cur_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit;
         s1_col_ff  <= col_ff - AddrW'(1);
         s1_row_ff  <= row_ff - RowW'(1);
         s1_cur_ff  <= cur;
      end
      if (s1_adv) begin
         rsp_col_ff    <= s1_col_ff;
         rsp_row_ff    <= s1_row_ff;
         rsp_marked_ff <= marked;
         if (marked) begin
            rsp_pix_ff <= '{red: ChanMax, green: '0, blue: '0};
         end else begin
            rsp_pix_ff <= ul_ff;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_red   = rsp_pix_ff.red;
   assign rsp_out_green = rsp_pix_ff.green;
   assign rsp_out_blue  = rsp_pix_ff.blue;
   assign rsp_marked    = rsp_marked_ff;

`ifndef SYNTHESIS
   // a marked beat always carries pure red
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_marked |-> rsp_out_red == ChanMax && rsp_out_green == '0
                                  && rsp_out_blue == '0)
      else $error("marked beat is not pure red");

   // input is held back only when the compare stage and output register are full
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with room in the pipeline");

   // a taken pixel always lands in the compare stage
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted pixel lost before compare stage");

   // a reporting pixel reaches the output register when it moves on
   assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_emit_ff |=> rsp_valid)
      else $error("result dropped at output register");
`endif

endmodule
